// ===== src/cfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the command frame parser modules.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned PosWidth  = 7;
   localparam int unsigned LenWidth  = 6;
   localparam int unsigned IdxWidth  = 5;

   localparam logic [ByteWidth-1:0] CharPercent = 8'h25;
   localparam logic [ByteWidth-1:0] CharSpace   = 8'h20;
   localparam logic [ByteWidth-1:0] CharPeriod  = 8'h2E;
   localparam logic [ByteWidth-1:0] TokenLow    = 8'd47;
   localparam logic [ByteWidth-1:0] TokenHigh   = 8'd127;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_OK   = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TOKEN_CMD  = 2'd0,
      TOKEN_ATTR = 2'd1,
      TOKEN_VAL  = 2'd2
   } token_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_TOKEN0 = 4'b0010,
      PH_TOKEN1 = 4'b0100,
      PH_TOKEN2 = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [1:0]          token_id;
      logic [ByteWidth-1:0] char_code;
      logic [IdxWidth-1:0] char_index;
      logic                frame_end;
   } rsp_type;

endpackage

// ===== src/cfp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_req_if
// Request channel: one line byte with its start-of-line mark.
// ----------------------------------------------------------------------------
interface cfp_req_if;
   logic                          valid;
   logic                          ready;
   logic [cfp_pkg::ByteWidth-1:0] data_byte;
   logic                          line_start;

   modport source (output valid, output data_byte, output line_start, input ready);
   modport sink   (input valid, input data_byte, input line_start, output ready);
endinterface

// ===== src/cfp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_rsp_if
// Result channel: token byte, frame ok or frame error.
// ----------------------------------------------------------------------------
interface cfp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    result_kind;
   logic [1:0]                    token_id;
   logic [cfp_pkg::ByteWidth-1:0] char_code;
   logic [cfp_pkg::IdxWidth-1:0]  char_index;
   logic                          frame_end;

   modport source (output valid, output result_kind, output token_id, output char_code,
                   output char_index, output frame_end, input ready);
   modport sink   (input valid, input result_kind, input token_id, input char_code,
                   input char_index, input frame_end, output ready);
endinterface

// ===== src/command_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_parser_unit
// Checks a received line against '%' command ' ' attribute ' ' value '.'.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one line byte per request, with line_start high on the
//   first byte of a line. rsp_bus returns token bytes tagged with token
//   number and index, then one ok or error result closing the frame.
//   Requests that produce nothing (leading '%', spaces, idle bytes) are
//   still taken like any other request.
// Throughput and result path:
//   One request per cycle while req_bus.ready is high. Each result is registered
//   in the result register or the skid entry as the frame state registers update.
// Reset:
//   Synchronous, active high. The parser goes idle and ignores bytes until
//   a request with line_start arrives; both result slots empty.
// Stalls:
//   A result register plus one skid entry decouple the channels. While
//   rsp_bus is stalled, requests are still taken until a second result sits
//   in the skid entry; req_bus.ready then drops until the result register drains.
// ----------------------------------------------------------------------------
module command_frame_parser_unit #(
   parameter int unsigned TOKEN_MAX = 32,
   parameter int unsigned LINE_MAX  = 64
) (
   input  logic      clock,
   input  logic      reset,
   cfp_req_if.sink   req_bus,
   cfp_rsp_if.source rsp_bus
);

   logic             req_accept;
   logic             push;
   logic             space;
   cfp_pkg::rsp_type result;

   assign req_bus.ready = space;
   assign req_accept    = req_bus.valid && space;

   cfp_parse #(
      .TOKEN_MAX (TOKEN_MAX),
      .LINE_MAX  (LINE_MAX)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_bus.data_byte),
      .line_start (req_bus.line_start),
      .push       (push),
      .result     (result)
   );

   cfp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .space     (space),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== src/cfp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_parse
// Frame state registers and the per-byte phase update.
// ----------------------------------------------------------------------------
module cfp_parse #(
   parameter int unsigned TOKEN_MAX = 32,
   parameter int unsigned LINE_MAX  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [cfp_pkg::ByteWidth-1:0] data_byte,
   input  logic                          line_start,
   output logic                          push,
   output cfp_pkg::rsp_type              result
);

   localparam logic [cfp_pkg::LenWidth-1:0] TokMax  = cfp_pkg::LenWidth'(TOKEN_MAX);
   localparam logic [cfp_pkg::PosWidth-1:0] LineMax = cfp_pkg::PosWidth'(LINE_MAX);
   localparam logic [cfp_pkg::PosWidth-1:0] LineLast = cfp_pkg::PosWidth'(LINE_MAX - 1);

   cfp_pkg::phase_type              phase_ff, phase_in;
   logic [cfp_pkg::PosWidth-1:0]    pos_ff, pos_in;
   logic [cfp_pkg::LenWidth-1:0]    len_ff, len_in;
   logic [1:0]                      tok;
   logic                            is_token;

   assign is_token = (data_byte > cfp_pkg::TokenLow) && (data_byte < cfp_pkg::TokenHigh);

   always_comb begin
      unique case (phase_ff)
         cfp_pkg::PH_TOKEN1: tok = cfp_pkg::TOKEN_ATTR;
         cfp_pkg::PH_TOKEN2: tok = cfp_pkg::TOKEN_VAL;
         default:            tok = cfp_pkg::TOKEN_CMD;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      push     = 1'b0;
      result   = '0;
      if (accept) begin
         if (line_start) begin
            len_in = '0;
            if (data_byte == cfp_pkg::CharPercent) begin
               pos_in   = cfp_pkg::PosWidth'(1);
               phase_in = cfp_pkg::PH_TOKEN0;
            end else begin
               pos_in             = '0;
               phase_in           = cfp_pkg::PH_IDLE;
               push               = 1'b1;
               result.result_kind = cfp_pkg::KIND_ERR;
               result.frame_end   = 1'b1;
            end
         end else if (phase_ff != cfp_pkg::PH_IDLE) begin
            if (pos_ff >= LineMax) begin
               phase_in           = cfp_pkg::PH_IDLE;
               push               = 1'b1;
               result.result_kind = cfp_pkg::KIND_ERR;
               result.frame_end   = 1'b1;
            end else if (is_token && (len_ff < TokMax) && (pos_ff < LineLast)) begin
               len_in             = len_ff + cfp_pkg::LenWidth'(1);
               pos_in             = pos_ff + cfp_pkg::PosWidth'(1);
               push               = 1'b1;
               result.result_kind = cfp_pkg::KIND_BYTE;
               result.token_id    = tok;
               result.char_code   = data_byte;
               result.char_index  = len_ff[cfp_pkg::IdxWidth-1:0];
            end else if (phase_ff != cfp_pkg::PH_TOKEN2) begin
               if (data_byte == cfp_pkg::CharSpace) begin
                  phase_in = (phase_ff == cfp_pkg::PH_TOKEN0) ? cfp_pkg::PH_TOKEN1
                                                              : cfp_pkg::PH_TOKEN2;
                  len_in   = '0;
                  pos_in   = pos_ff + cfp_pkg::PosWidth'(1);
               end else begin
                  phase_in           = cfp_pkg::PH_IDLE;
                  push               = 1'b1;
                  result.result_kind = cfp_pkg::KIND_ERR;
                  result.frame_end   = 1'b1;
               end
            end else begin
               phase_in           = cfp_pkg::PH_IDLE;
               push               = 1'b1;
               result.result_kind = (data_byte == cfp_pkg::CharPeriod) ? cfp_pkg::KIND_OK
                                                                       : cfp_pkg::KIND_ERR;
               result.frame_end   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfp_pkg::PH_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ===== src/cfp_rsp_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_rsp_buf
// Result register with a skid stage toward the result channel.
// ----------------------------------------------------------------------------
module cfp_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfp_pkg::rsp_type push_data,
   output logic             space,
   cfp_rsp_if.source        rsp_bus
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   cfp_pkg::rsp_type out_data_ff, out_data_in;
   cfp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             out_free;

   assign space    = !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_kind = out_data_ff.result_kind;
   assign rsp_bus.token_id    = out_data_ff.token_id;
   assign rsp_bus.char_code   = out_data_ff.char_code;
   assign rsp_bus.char_index  = out_data_ff.char_index;
   assign rsp_bus.frame_end   = out_data_ff.frame_end;

endmodule

// ===== src/cfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks on the result channel of the command frame parser.
// ----------------------------------------------------------------------------
module cfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    result_kind,
   input logic [1:0]                    token_id,
   input logic [cfp_pkg::ByteWidth-1:0] char_code,
   input logic [cfp_pkg::IdxWidth-1:0]  char_index,
   input logic                          frame_end
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (result_kind == cfp_pkg::KIND_BYTE || result_kind == cfp_pkg::KIND_OK ||
                     result_kind == cfp_pkg::KIND_ERR))
      else $error("illegal result kind");

   a_end_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (frame_end == (result_kind != cfp_pkg::KIND_BYTE)))
      else $error("frame_end disagrees with result kind");

   a_status_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> (token_id == '0 && char_code == '0 && char_index == '0))
      else $error("status result carries token fields");

endmodule

bind command_frame_parser_unit cfp_checker u_cfp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .result_kind (rsp_bus.result_kind),
   .token_id    (rsp_bus.token_id),
   .char_code   (rsp_bus.char_code),
   .char_index  (rsp_bus.char_index),
   .frame_end   (rsp_bus.frame_end)
);
